[rtl/core/cpm_pkg.sv]
// Package for the cosine pattern matcher: sizes, transaction structs,
// register indexes and the controller state type. No dependencies.
package cpm_pkg;

    localparam int MAX_REFS    = 16;
    localparam int MAX_LEN     = 64;
    localparam int OFFSET_BITS = 16;

    localparam int SLOT_W  = $clog2(MAX_REFS);
    localparam int CNT_W   = $clog2(MAX_REFS + 1);
    localparam int LIDX_W  = $clog2(MAX_LEN);
    localparam int IDX_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = SLOT_W + LIDX_W;
    localparam int ACC_W   = 2 * OFFSET_BITS + LIDX_W;
    localparam int MUL_H   = (ACC_W + 1) / 2;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int SIM_W   = 16;
    localparam int Q_W     = 2 * (SIM_W - 1) + 1;
    localparam int DCNT_W  = $clog2(Q_W);

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    localparam logic [15:0] THRESHOLD_RST = 16'd26214;
    localparam logic [4:0]  CAPACITY_RST  = 5'd16;

    typedef struct packed {
        logic        command;
        logic [15:0] offset_value;
        logic        has_value;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [15:0] top_score;
        logic        is_match;
        logic [4:0]  reference_count;
        logic        truncated;
    } t_result;

    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] rnorm;
        logic [ACC_W-1:0] qnorm;
    } t_accum;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_SRD,
        S_SLD,
        S_MP0,
        S_MP1,
        S_MD0,
        S_MD1,
        S_DIV,
        S_SQRT,
        S_SNXT
    } t_state;

endpackage

[rtl/core/cosine_pattern_matcher.sv]
// Cosine pattern matcher top level: reference store, per-slot accumulators,
// similarity search with shared multiplier, divider and square root.
// Depends on cpm_pkg.
// Learn items are taken back to back; a learn end reports on the next cycle.
// A query element holds busy while the accumulators update (one read-modify-write
// per reference that reaches that element, pipelined on the memory port).
// A query end then scores each stored reference in turn (38x19 multiplier,
// 31-step divider, 16-step square root; skipped where the score is zero outright);
// the result strobes once no reference is left. The receiver cannot stall.
// Synchronous active-low reset clears control state, not the store or accumulators.
module cosine_pattern_matcher
    import cpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    logic [15:0]      r_store [MAX_REFS*MAX_LEN];
    t_accum           r_accm  [MAX_REFS];
    logic [IDX_W-1:0] r_len   [MAX_REFS];

    logic [15:0]        r_thr;
    logic [4:0]         r_cap;
    logic [SLOT_W-1:0]  r_oldest;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic               r_ovf, r_open, r_kind, r_last;
    logic [MAX_REFS-1:0] r_vld_acc;
    logic [15:0]        r_off;
    logic [LIDX_W-1:0]  r_eidx;
    logic [CNT_W-1:0]   r_k;
    logic               r_pvld;
    logic [SLOT_W-1:0]  r_pslot;
    logic [15:0]        r_ref_q;
    t_accum             r_acc_q;
    logic               r_rvld;
    logic               r_lnz;
    logic [ACC_W-1:0]   r_dot, r_rn, r_qn;
    logic [PROD_W-1:0]  r_p, r_d, r_rem;
    logic [Q_W-1:0]     r_nlo, r_q;
    logic [DCNT_W-1:0]  r_cnt;
    logic [SIM_W-1:0]   r_s, r_best;
    logic               r_out_vld;
    t_result            r_out;

    logic               accept, kind_e, ovf_e, elem_ok, ovf_n, learn_full;
    logic [IDX_W-1:0]   idx_e, idx_n;
    logic [CNT_W-1:0]   tgt_sum, k_sum, cap_eff, count_n;
    logic [SLOT_W-1:0]  tgt, slot_k, oldest_n;
    logic               issue, act, zero_sim, cfg_wr;
    t_accum             acc_rd, acc_wb;
    logic [31:0]        m_ro, m_rr, m_oo;
    logic [ACC_W-1:0]   mul_a;
    logic [MUL_H-1:0]   mul_b;
    logic [ACC_W+MUL_H-1:0] mul_out;
    logic [PROD_W-1:0]  d_full;
    logic [PROD_W:0]    div_t, div_r;
    logic               div_ge;
    logic [SIM_W-1:0]   cand;
    logic [2*SIM_W-1:0] cand_sq;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, r_cap} : {16'd0, r_thr};
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    assign kind_e  = r_open ? r_kind : i_item.command;
    assign idx_e   = r_open ? r_idx : '0;
    assign ovf_e   = r_open ? r_ovf : 1'b0;
    assign elem_ok = i_item.has_value && (idx_e < IDX_W'(MAX_LEN));
    assign ovf_n   = ovf_e | (i_item.has_value & ~elem_ok);
    assign idx_n   = idx_e + IDX_W'(elem_ok);

    assign tgt_sum = CNT_W'(r_oldest) + r_count;
    assign tgt     = tgt_sum[SLOT_W-1:0];
    assign k_sum   = CNT_W'(r_oldest) + r_k;
    assign slot_k  = k_sum[SLOT_W-1:0];

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > 5'(MAX_REFS)) begin
            cap_eff = CNT_W'(MAX_REFS);
        end else begin
            cap_eff = r_cap;
        end
    end
    assign learn_full = (r_count >= cap_eff);
    assign count_n    = learn_full ? r_count : r_count + CNT_W'(1);
    assign oldest_n   = learn_full ? r_oldest + SLOT_W'(1) : r_oldest;

    assign issue = (r_k < r_count);
    assign act   = ({1'b0, r_eidx} < r_len[slot_k]);

    assign acc_rd = r_rvld ? r_acc_q : '0;
    assign m_ro   = 32'(r_ref_q) * 32'(r_off);
    assign m_rr   = 32'(r_ref_q) * 32'(r_ref_q);
    assign m_oo   = 32'(r_off) * 32'(r_off);
    always_comb begin
        acc_wb.dot   = acc_rd.dot   + ACC_W'(m_ro);
        acc_wb.rnorm = acc_rd.rnorm + ACC_W'(m_rr);
        acc_wb.qnorm = acc_rd.qnorm + ACC_W'(m_oo);
    end

    assign zero_sim = ~r_lnz || (r_idx == '0) || (acc_rd.rnorm == '0) || (acc_rd.qnorm == '0);

    assign mul_a = (r_state == S_MP0 || r_state == S_MP1) ? r_rn : r_dot;
    always_comb begin
        unique case (r_state)
            S_MP0:   mul_b = r_qn[MUL_H-1:0];
            S_MP1:   mul_b = MUL_H'(r_qn[ACC_W-1:MUL_H]);
            S_MD0:   mul_b = r_dot[MUL_H-1:0];
            S_MD1:   mul_b = MUL_H'(r_dot[ACC_W-1:MUL_H]);
            default: mul_b = '0;
        endcase
    end
    assign mul_out = (ACC_W+MUL_H)'(mul_a) * (ACC_W+MUL_H)'(mul_b);
    assign d_full  = r_d + (PROD_W'(mul_out) << MUL_H);

    assign div_t  = {r_rem, r_nlo[Q_W-1]};
    assign div_ge = (div_t >= {1'b0, r_p});
    assign div_r  = div_ge ? div_t - {1'b0, r_p} : div_t;

    assign cand    = r_s | (SIM_W'(1) << r_cnt[$clog2(SIM_W)-1:0]);
    assign cand_sq = (2*SIM_W)'(cand) * (2*SIM_W)'(cand);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !kind_e) begin
                    if (elem_ok) begin
                        n_state = S_ACC;
                    end else if (i_item.last) begin
                        n_state = S_SRD;
                    end
                end
            end
            S_ACC: begin
                if (!issue && !r_pvld) begin
                    n_state = r_last ? S_SRD : S_IDLE;
                end
            end
            S_SRD:  n_state = (r_k == r_count) ? S_IDLE : S_SLD;
            S_SLD:  n_state = zero_sim ? S_SRD : S_MP0;
            S_MP0:  n_state = S_MP1;
            S_MP1:  n_state = S_MD0;
            S_MD0:  n_state = S_MD1;
            S_MD1:  n_state = S_DIV;
            S_DIV:  n_state = (r_cnt == '0) ? S_SQRT : S_DIV;
            S_SQRT: n_state = (r_cnt == '0) ? S_SNXT : S_SQRT;
            S_SNXT: n_state = S_SRD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // reference store and accumulator memory
    always_ff @(posedge i_clk) begin
        if (accept && kind_e && elem_ok) begin
            r_store[{tgt, idx_e[LIDX_W-1:0]}] <= i_item.offset_value[OFFSET_BITS-1:0];
        end
        r_ref_q <= r_store[{slot_k, r_eidx}];
        if (r_state == S_ACC && r_pvld) begin
            r_accm[r_pslot] <= acc_wb;
        end
        r_acc_q <= r_accm[slot_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RST;
            r_cap     <= CAPACITY_RST;
            r_oldest  <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_open    <= 1'b0;
            r_kind    <= 1'b0;
            r_last    <= 1'b0;
            r_vld_acc <= '0;
            r_k       <= '0;
            r_pvld    <= 1'b0;
            r_rvld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_REFS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_out_vld <= (r_state == S_IDLE && accept && kind_e && i_item.last) ||
                         (r_state == S_SRD && r_k == r_count);
            r_rvld    <= r_vld_acc[slot_k];
            if (cfg_wr) begin
                if (paddr[2] == REG_CAPACITY) begin
                    r_cap <= pwdata[4:0];
                end else begin
                    r_thr <= pwdata[15:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_open <= ~i_item.last;
                        r_kind <= kind_e;
                        r_idx  <= idx_n;
                        r_ovf  <= ovf_n;
                        r_last <= i_item.last;
                        r_off  <= i_item.offset_value[OFFSET_BITS-1:0];
                        r_eidx <= idx_e[LIDX_W-1:0];
                        r_k    <= '0;
                        r_pvld <= 1'b0;
                        r_best <= '0;
                        if (!r_open) begin
                            r_vld_acc <= '0;
                        end
                        if (kind_e && i_item.last) begin
                            r_len[tgt]  <= idx_n;
                            r_count     <= count_n;
                            r_oldest    <= oldest_n;
                            r_out.top_score       <= '0;
                            r_out.is_match        <= 1'b0;
                            r_out.reference_count <= 5'(count_n);
                            r_out.truncated       <= ovf_n;
                        end
                    end
                end
                S_ACC: begin
                    r_pvld  <= issue & act;
                    r_pslot <= slot_k;
                    if (issue) begin
                        r_k <= r_k + CNT_W'(1);
                    end
                    if (r_pvld) begin
                        r_vld_acc[r_pslot] <= 1'b1;
                    end
                    if (!issue && !r_pvld) begin
                        r_k <= '0;
                    end
                end
                S_SRD: begin
                    r_lnz <= (r_len[slot_k] != '0);
                    if (r_k == r_count) begin
                        r_out.top_score       <= r_best;
                        r_out.is_match        <= (r_best >= r_thr);
                        r_out.reference_count <= 5'(r_count);
                        r_out.truncated       <= r_ovf;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                S_SLD: begin
                    r_dot <= acc_rd.dot;
                    r_rn  <= acc_rd.rnorm;
                    r_qn  <= acc_rd.qnorm;
                end
                S_MP0: r_p <= PROD_W'(mul_out);
                S_MP1: r_p <= r_p + (PROD_W'(mul_out) << MUL_H);
                S_MD0: r_d <= PROD_W'(mul_out);
                S_MD1: begin
                    r_rem <= d_full >> 1;
                    r_nlo <= {d_full[0], (Q_W-1)'(0)};
                    r_q   <= '0;
                    r_cnt <= DCNT_W'(Q_W - 1);
                end
                S_DIV: begin
                    r_rem <= div_r[PROD_W-1:0];
                    r_nlo <= r_nlo << 1;
                    r_q   <= {r_q[Q_W-2:0], div_ge};
                    if (r_cnt == '0) begin
                        r_cnt <= DCNT_W'(SIM_W - 1);
                        r_s   <= '0;
                    end else begin
                        r_cnt <= r_cnt - DCNT_W'(1);
                    end
                end
                S_SQRT: begin
                    if (cand_sq <= (2*SIM_W)'(r_q)) begin
                        r_s <= cand;
                    end
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - DCNT_W'(1);
                    end
                end
                S_SNXT: begin
                    if (r_s > r_best) begin
                        r_best <= r_s;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
